// ----- hw/rtl/uart_error_storm_limiter_assert.svh -----
// Assertion macros for the UART error-storm limiter.
// Used by uesl_core.sv and uart_error_storm_limiter.sv; needs clock and reset in scope.
`ifndef UART_ERROR_STORM_LIMITER_ASSERT_SVH
`define UART_ERROR_STORM_LIMITER_ASSERT_SVH

// same-cycle implication
`define UESL_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("uesl assertion failed");

// next-cycle implication
`define UESL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("uesl assertion failed");

`endif

// ----- hw/rtl/uesl_pkg.sv -----
// Types and constants shared by the UART error-storm limiter modules.
// No dependencies.
`timescale 1ns / 1ps

package uesl_pkg;

   localparam logic [1:0] CMD_BYTE  = 2'd0;
   localparam logic [1:0] CMD_ERROR = 2'd1;
   localparam logic [1:0] CMD_POLL  = 2'd2;

   localparam logic [1:0] PORT_UNKNOWN = 2'd0;
   localparam logic [1:0] PORT_MAIN    = 2'd1;
   localparam logic [1:0] PORT_SECOND  = 2'd2;

   localparam logic [1:0] REG_BURST_WINDOW = 2'd0;
   localparam logic [1:0] REG_BURST_LIMIT  = 2'd1;
   localparam logic [1:0] REG_PAUSE        = 2'd2;

   localparam logic [15:0] BURST_WINDOW_RESET = 16'd100;
   localparam logic [15:0] BURST_LIMIT_RESET  = 16'd20;
   localparam logic [15:0] PAUSE_RESET        = 16'd200;
   localparam logic [15:0] BURST_MAX          = 16'hFFFF;
   localparam logic [31:0] COUNT_MAX          = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  command;
      logic        port;
      logic [7:0]  rx_data;
      logic        overrun_flag;
      logic        framing_flag;
      logic        noise_flag;
      logic        parity_flag;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        byte_valid;
      logic [7:0]  byte_out;
      logic [1:0]  last_port;
      logic        receive_paused;
      logic        restart_receive;
      logic [31:0] overrun_count;
      logic [31:0] framing_count;
      logic [31:0] noise_count;
      logic [31:0] parity_count;
      logic [15:0] burst_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] burst_window_ms;
      logic [15:0] burst_limit;
      logic [15:0] pause_ms;
   } cfg_type;

endpackage

// ----- hw/rtl/uesl_core.sv -----
// Limiter state and per-word update: counters, burst tracking and pause deadline.
// Depends on uesl_pkg and uart_error_storm_limiter_assert.svh.
`timescale 1ns / 1ps
`include "uart_error_storm_limiter_assert.svh"

module uesl_core
   import uesl_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    fire,
   input  req_type item,
   output rsp_type result
);

   logic [31:0] error_time_ff, error_time_in;
   logic [15:0] burst_level_ff, burst_level_in;
   logic        paused_ff, paused_in;
   logic [31:0] deadline_ff, deadline_in;
   logic [1:0]  port_seen_ff, port_seen_in;
   logic [31:0] overruns_ff, overruns_in;
   logic [31:0] framings_ff, framings_in;
   logic [31:0] noises_ff, noises_in;
   logic [31:0] parities_ff, parities_in;

   logic        count_en;
   logic        byte_valid;
   logic        restart;
   logic [31:0] gap;
   logic [31:0] poll_diff;

   function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic en);
      sat_inc = (en && v != COUNT_MAX) ? v + 32'd1 : v;
   endfunction

   assign gap       = item.now_ms - error_time_ff;
   assign poll_diff = item.now_ms - deadline_ff;

   always_comb begin
      error_time_in  = error_time_ff;
      burst_level_in = burst_level_ff;
      paused_in      = paused_ff;
      deadline_in    = deadline_ff;
      port_seen_in   = port_seen_ff;
      count_en       = 1'b0;
      byte_valid     = 1'b0;
      restart        = 1'b0;
      unique case (item.command)
         CMD_BYTE: begin
            if (item.port || !paused_ff) begin
               port_seen_in = item.port ? PORT_SECOND : PORT_MAIN;
               count_en     = 1'b1;
               byte_valid   = 1'b1;
            end
         end
         CMD_ERROR: begin
            if (!item.port && !paused_ff) begin
               if (gap <= {16'd0, cfg.burst_window_ms}) begin
                  if (burst_level_ff != BURST_MAX) begin
                     burst_level_in = burst_level_ff + 16'd1;
                  end
               end else begin
                  burst_level_in = 16'd1;
               end
               error_time_in = item.now_ms;
               count_en      = 1'b1;
               if (burst_level_in >= cfg.burst_limit) begin
                  paused_in   = 1'b1;
                  deadline_in = item.now_ms + {16'd0, cfg.pause_ms};
               end else begin
                  restart = 1'b1;
               end
            end
         end
         CMD_POLL: begin
            if (paused_ff && !poll_diff[31]) begin
               paused_in = 1'b0;
               restart   = 1'b1;
            end
         end
         default: begin
         end
      endcase
      overruns_in = sat_inc(overruns_ff, count_en && item.overrun_flag);
      framings_in = sat_inc(framings_ff, count_en && item.framing_flag);
      noises_in   = sat_inc(noises_ff, count_en && item.noise_flag);
      parities_in = sat_inc(parities_ff, count_en && item.parity_flag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_time_ff  <= '0;
         burst_level_ff <= '0;
         paused_ff      <= 1'b0;
         deadline_ff    <= '0;
         port_seen_ff   <= PORT_UNKNOWN;
         overruns_ff    <= '0;
         framings_ff    <= '0;
         noises_ff      <= '0;
         parities_ff    <= '0;
      end else if (fire) begin
         error_time_ff  <= error_time_in;
         burst_level_ff <= burst_level_in;
         paused_ff      <= paused_in;
         deadline_ff    <= deadline_in;
         port_seen_ff   <= port_seen_in;
         overruns_ff    <= overruns_in;
         framings_ff    <= framings_in;
         noises_ff      <= noises_in;
         parities_ff    <= parities_in;
      end
   end

   always_comb begin
      result.byte_valid      = byte_valid;
      result.byte_out        = byte_valid ? item.rx_data : 8'd0;
      result.last_port       = port_seen_in;
      result.receive_paused  = paused_in;
      result.restart_receive = restart;
      result.overrun_count   = overruns_in;
      result.framing_count   = framings_in;
      result.noise_count     = noises_in;
      result.parity_count    = parities_in;
      result.burst_count     = burst_level_in;
   end

   `UESL_ASSERT_IMPL(a_byte_only_on_byte_cmd, fire && result.byte_valid, item.command == CMD_BYTE)
   `UESL_ASSERT_IMPL(a_restart_not_paused, fire && result.restart_receive, !result.receive_paused)
   `UESL_ASSERT_NEXT(a_hold_when_idle, !fire, $stable(paused_ff) && $stable(burst_level_ff))
   `UESL_ASSERT_IMPL(a_pause_needs_error, fire && !paused_ff && paused_in, item.command == CMD_ERROR)

endmodule

// ----- hw/rtl/uart_error_storm_limiter.sv -----
// Top level of the UART error-storm limiter: input register, CSR port, result queue.
// Depends on uesl_pkg, uesl_core and uart_error_storm_limiter_assert.svh.
//
// Accepts one word per cycle while the result queue has room or rsp_ready is high, and
// returns exactly one result word per input word, in order. A word is held in the input
// register, is processed by uesl_core in a single pass and lands in a two-entry result
// queue, whose head drives rsp_valid and rsp_payload; the queue lets input keep flowing
// while a result waits. No clearing pass after reset.
// CSRs: 0x0 burst_window_ms, 0x4 burst_limit, 0x8 pause_ms,
// low 16 bits of each 32-bit word; write them only while the block is idle.
`timescale 1ns / 1ps
`include "uart_error_storm_limiter_assert.svh"

module uart_error_storm_limiter
   import uesl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type     cfg_ff;
   logic        csr_write;

   logic        in_valid_ff, in_valid_in;
   req_type     in_data_ff;
   logic        advance;
   rsp_type     result;

   rsp_type     q0_ff, q1_ff;
   logic [1:0]  count_ff, count_in;
   logic        pop;

   // config registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.burst_window_ms <= BURST_WINDOW_RESET;
         cfg_ff.burst_limit     <= BURST_LIMIT_RESET;
         cfg_ff.pause_ms        <= PAUSE_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_BURST_WINDOW: cfg_ff.burst_window_ms <= csr_pwdata[15:0];
            REG_BURST_LIMIT:  cfg_ff.burst_limit     <= csr_pwdata[15:0];
            REG_PAUSE:        cfg_ff.pause_ms        <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_BURST_WINDOW: csr_prdata = {16'd0, cfg_ff.burst_window_ms};
         REG_BURST_LIMIT:  csr_prdata = {16'd0, cfg_ff.burst_limit};
         REG_PAUSE:        csr_prdata = {16'd0, cfg_ff.pause_ms};
         default:          csr_prdata = 32'd0;
      endcase
   end

   // input register
   assign pop       = rsp_valid && rsp_ready;
   assign advance   = in_valid_ff && (count_ff != 2'd2 || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
   end

   uesl_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .fire   (advance),
      .item   (in_data_ff),
      .result (result)
   );

   // result queue, q0 is the head
   assign count_in    = count_ff + {1'b0, advance} - {1'b0, pop};
   assign rsp_valid   = count_ff != 2'd0;
   assign rsp_payload = q0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      unique case ({advance, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               q0_ff <= result;
            end else begin
               q1_ff <= result;
            end
         end
         2'b01: q0_ff <= q1_ff;
         2'b11: begin
            if (count_ff == 2'd1) begin
               q0_ff <= result;
            end else begin
               q0_ff <= q1_ff;
               q1_ff <= result;
            end
         end
         default: begin
         end
      endcase
   end

   `UESL_ASSERT_IMPL(a_queue_bound, 1'b1, count_ff != 2'd3)
   `UESL_ASSERT_IMPL(a_no_push_when_full, count_ff == 2'd2 && !rsp_ready, !advance)
   `UESL_ASSERT_NEXT(a_push_fills, advance && !pop, rsp_valid)

endmodule
